// ----- src/grid_line_tracker_top_macros.svh -----
// Assertion macros for the grid line tracker.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef GRID_LINE_TRACKER_TOP_MACROS_SVH
`define GRID_LINE_TRACKER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GLT_ASSERT(label, expr, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define GLT_ASSERT_NEXT(label, pre, post, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GLT_ASSERT(label, expr, msg)
`define GLT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- src/glt_pkg.sv -----
// ----------------------------------------------------------------------------
// glt_pkg
// Types, codes and constants shared by the grid line tracker modules.
// ----------------------------------------------------------------------------
package glt_pkg;

    localparam int NUM_SENSORS     = 5;
    localparam int NUM_TRACKED     = 4;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int COUNT_BITS      = 8;
    localparam int POS_BITS        = 4;
    localparam int THRESHOLD_RESET = 1400;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Sensor lanes, which are also the threshold register indexes.
    localparam int SENS_FL = 0;
    localparam int SENS_FR = 1;
    localparam int SENS_FB = 2;
    localparam int SENS_SL = 3;
    localparam int SENS_SR = 4;

    // Tracked change flags and transition counters.
    localparam int TRK_FL = 0;
    localparam int TRK_FR = 1;
    localparam int TRK_SL = 2;
    localparam int TRK_SR = 3;

    // Position codes: front left, front right, side left, side right, black is 1.
    localparam logic [POS_BITS-1:0] POS_FR       = 4'd4;
    localparam logic [POS_BITS-1:0] POS_FR_SR    = 4'd5;
    localparam logic [POS_BITS-1:0] POS_FR_SL    = 4'd6;
    localparam logic [POS_BITS-1:0] POS_FR_SL_SR = 4'd7;
    localparam logic [POS_BITS-1:0] POS_FL       = 4'd8;
    localparam logic [POS_BITS-1:0] POS_FL_SR    = 4'd9;
    localparam logic [POS_BITS-1:0] POS_FL_SL    = 4'd10;
    localparam logic [POS_BITS-1:0] POS_FL_SL_SR = 4'd11;

    typedef enum logic
    {
        KIND_START  = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        MOVE_FORWARD  = 3'd0,
        MOVE_BACKWARD = 3'd1,
        MOVE_LEFT     = 3'd2,
        MOVE_RIGHT    = 3'd3,
        MOVE_STOPPED  = 3'd4
    } move_t;

    typedef enum logic [1:0]
    {
        COMP_ON_TRACK = 2'd0,
        COMP_RIGHT    = 2'd1,
        COMP_LEFT     = 2'd2
    } comp_t;

    typedef struct packed
    {
        logic step;
        logic clear;
    } glt_cnt_ctrl_t;

    typedef struct packed
    {
        comp_t               compensation;
        logic                move_finished;
        logic [POS_BITS-1:0] position_code;
        logic                position_known;
        logic                on_cross;
        logic                colour_order;
        logic                needs_alignment;
    } glt_result_t;

endpackage

// ----- src/glt_sense_lane.sv -----
// ----------------------------------------------------------------------------
// glt_sense_lane
// Classifies one IR reading as black when it is not below its threshold.
// ----------------------------------------------------------------------------
module glt_sense_lane
    import glt_pkg::*;
#(
    parameter int READING_BITS = 12
)
(
    input  logic [READING_BITS-1:0] reading,
    input  logic [READING_BITS-1:0] threshold,
    output logic                    black
);

    assign black = (reading >= threshold);

endmodule

// ----- src/glt_count_lane.sv -----
// ----------------------------------------------------------------------------
// glt_count_lane
// Change flag and saturating transition counter of one tracked sensor.
// ----------------------------------------------------------------------------
module glt_count_lane
    import glt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  glt_cnt_ctrl_t         ctrl,
    input  logic                  changed,
    output logic [COUNT_BITS-1:0] count_next
);

    logic                  flag_reg;
    logic                  flag_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  toggle;

    // A flip of the change flag counts as one transition.
    assign toggle     = changed ^ flag_reg;
    assign flag_next  = changed;
    assign count_next = (toggle && (count_reg != COUNT_MAX)) ?
                        (count_reg + COUNT_BITS'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.clear)
            begin
                flag_reg  <= 1'b0;
                count_reg <= '0;
            end
            else
            begin
                flag_reg  <= flag_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

// ----- src/glt_merge.sv -----
// ----------------------------------------------------------------------------
// glt_merge
// Combines the lane results with the tracking state into one result.
// ----------------------------------------------------------------------------
module glt_merge
    import glt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  kind_t                  kind,
    input  move_t                  movement,
    input  logic [NUM_SENSORS-1:0] black,
    input  logic [COUNT_BITS-1:0]  count [NUM_TRACKED],
    output logic [NUM_TRACKED-1:0] changed,
    output glt_cnt_ctrl_t          ctrl,
    output glt_result_t            result
);

    logic [2:0]          fref_reg, fref_next, fref_mod;
    logic [1:0]          sref_reg, sref_next;
    logic                flipped_reg, flipped_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                colour_reg, colour_next;
    logic                cross_reg, cross_next;

    logic fl, fr, fb, sl, sr;
    logic lc, rc, slc, src;
    logic pair, cond, fwd, done, finish, align;
    comp_t comp;

    assign fl = black[SENS_FL];
    assign fr = black[SENS_FR];
    assign fb = black[SENS_FB];
    assign sl = black[SENS_SL];
    assign sr = black[SENS_SR];

    assign lc  = fl ^ fref_reg[0];
    assign rc  = fr ^ fref_reg[1];
    assign slc = sl ^ sref_reg[0];
    assign src = sr ^ sref_reg[1];

    assign changed[TRK_FL] = lc;
    assign changed[TRK_FR] = rc;
    assign changed[TRK_SL] = slc;
    assign changed[TRK_SR] = src;

    always_comb
    begin
        fref_next    = fref_reg;
        fref_mod     = fref_reg;
        sref_next    = sref_reg;
        flipped_next = flipped_reg;
        pos_next     = pos_reg;
        colour_next  = colour_reg;
        cross_next   = cross_reg;
        comp         = COMP_ON_TRACK;
        finish       = 1'b0;
        align        = 1'b0;
        pair         = 1'b0;
        cond         = 1'b0;
        fwd          = 1'b0;
        done         = 1'b0;

        if (kind == KIND_START)
        begin
            fref_next = {fb, fr, fl};
            sref_next = {sr, sl};
            align     = (fl == fr);
            pos_next  = {fl, fr, sl, sr};
            unique case (pos_next)
                POS_FR, POS_FR_SR, POS_FR_SL_SR:
                begin
                    sref_next   = 2'b10;
                    colour_next = 1'b0;
                    cross_next  = 1'b0;
                end
                POS_FR_SL:
                begin
                    sref_next   = 2'b01;
                    colour_next = 1'b1;
                    cross_next  = 1'b1;
                end
                POS_FL, POS_FL_SL, POS_FL_SL_SR:
                begin
                    sref_next   = 2'b01;
                    colour_next = 1'b1;
                    cross_next  = 1'b0;
                end
                POS_FL_SR:
                begin
                    sref_next   = 2'b10;
                    colour_next = 1'b0;
                    cross_next  = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (movement)
                MOVE_FORWARD, MOVE_BACKWARD:
                begin
                    fwd = (movement == MOVE_FORWARD);
                    // The front references flip once, when both front sensors change.
                    if (!flipped_reg && lc && rc)
                    begin
                        flipped_next = 1'b1;
                        fref_mod     = fref_reg ^ 3'b011;
                    end
                    fref_next = fref_mod;
                    pair = (fl == fr);
                    cond = pair && (fl != fb);
                    if (fwd)
                    begin
                        cond = cond && (fl != fref_mod[0]);
                    end
                    if (cond)
                    begin
                        comp = fwd ? COMP_RIGHT : COMP_LEFT;
                    end
                    else if (pair && (fl == fb))
                    begin
                        comp = fwd ? COMP_LEFT : COMP_RIGHT;
                    end
                    if (slc && src)
                    begin
                        finish       = 1'b1;
                        colour_next  = ~colour_reg;
                        flipped_next = 1'b0;
                    end
                end
                MOVE_LEFT, MOVE_RIGHT:
                begin
                    fwd = (movement == MOVE_LEFT);
                    unique case (pos_reg)
                        POS_FR_SR, POS_FL_SL:
                        begin
                            done = fwd ? (count[TRK_SR] != '0) : (count[TRK_SL] != '0);
                        end
                        POS_FR_SL, POS_FL_SR:
                        begin
                            done = ((count[TRK_SL] != '0) && (count[TRK_SR] != '0)) ||
                                   (fwd ? (count[TRK_SR] == COUNT_BITS'(2))
                                        : (count[TRK_SL] == COUNT_BITS'(2)));
                        end
                        POS_FR, POS_FL_SL_SR, POS_FR_SL_SR, POS_FL:
                        begin
                            done = fwd ? (count[TRK_FL] != '0) : (count[TRK_FR] != '0);
                        end
                        default:
                        begin
                            done = 1'b0;
                        end
                    endcase
                    if (done)
                    begin
                        finish      = 1'b1;
                        colour_next = ~colour_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ctrl.step  = accept && (kind == KIND_SAMPLE);
    assign ctrl.clear = finish;

    assign result.compensation    = comp;
    assign result.move_finished   = finish;
    assign result.position_code   = pos_next;
    assign result.position_known  = (pos_next >= POS_FR) && (pos_next <= POS_FL_SL_SR);
    assign result.on_cross        = cross_next;
    assign result.colour_order    = colour_next;
    assign result.needs_alignment = align;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fref_reg    <= '0;
            sref_reg    <= '0;
            flipped_reg <= 1'b0;
            pos_reg     <= '0;
            colour_reg  <= 1'b1;
            cross_reg   <= 1'b0;
        end
        else if (accept)
        begin
            fref_reg    <= fref_next;
            sref_reg    <= sref_next;
            flipped_reg <= flipped_next;
            pos_reg     <= pos_next;
            colour_reg  <= colour_next;
            cross_reg   <= cross_next;
        end
    end

endmodule

// ----- src/grid_line_tracker_top.sv -----
// ----------------------------------------------------------------------------
// grid_line_tracker_top
// Latency: an accepted input transfer has its result in the output register in the next cycle.
// Throughput: one item per cycle while the output is not stalled; the tracking state loop runs through the merge.
// Reset: rst_n clears the tracking state, sets thresholds to 1400 and empties the output.
// ----------------------------------------------------------------------------
`include "grid_line_tracker_top_macros.svh"

module grid_line_tracker_top
    import glt_pkg::*;
#(
    parameter int READING_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [READING_BITS-1:0]   cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      kind,
    input  logic [2:0]                movement,
    input  logic [READING_BITS-1:0]   front_left_reading,
    input  logic [READING_BITS-1:0]   front_right_reading,
    input  logic [READING_BITS-1:0]   front_backup_reading,
    input  logic [READING_BITS-1:0]   side_left_reading,
    input  logic [READING_BITS-1:0]   side_right_reading,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                compensation,
    output logic                      move_finished,
    output logic [POS_BITS-1:0]       position_code,
    output logic                      position_known,
    output logic                      on_cross,
    output logic                      colour_order,
    output logic                      needs_alignment
);

    // Threshold reset value, cut to the reading width as the compare sees it.
    localparam logic [READING_BITS-1:0] THRESH_INIT = READING_BITS'(THRESHOLD_RESET);

    // The five thresholds live in flip-flops. Each lane reads its own entry, so
    // this is a register file with one write port and fixed read taps.
    logic [READING_BITS-1:0] thresh_reg [NUM_SENSORS];
    logic [READING_BITS-1:0] reading    [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]  black;

    logic [NUM_TRACKED-1:0]  changed;
    logic [COUNT_BITS-1:0]   count_next [NUM_TRACKED];
    glt_cnt_ctrl_t           cnt_ctrl;
    glt_result_t             result;
    glt_result_t             result_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    accept;

    // A transfer is taken whenever the output register is empty or being
    // drained in the same cycle, so items can follow each other every cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Configuration writes beyond the last threshold are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                thresh_reg[i] <= THRESH_INIT;
            end
        end
        else if (cfg_we && (cfg_index < CFG_INDEX_BITS'(NUM_SENSORS)))
        begin
            thresh_reg[cfg_index] <= cfg_data;
        end
    end

    assign reading[SENS_FL] = front_left_reading;
    assign reading[SENS_FR] = front_right_reading;
    assign reading[SENS_FB] = front_backup_reading;
    assign reading[SENS_SL] = side_left_reading;
    assign reading[SENS_SR] = side_right_reading;

    // Classification lanes: one comparator per sensor, all in parallel.
    for (genvar g = 0; g < NUM_SENSORS; g++)
    begin : g_sense
        glt_sense_lane #(
            .READING_BITS (READING_BITS)
        ) u_sense (
            .reading   (reading[g]),
            .threshold (thresh_reg[g]),
            .black     (black[g])
        );
    end

    // Tracking lanes: the change flag and transition counter of each of the
    // four tracked sensors. The merge stage sees the updated counts in the
    // same cycle and decides whether the lanes clear.
    for (genvar g = 0; g < NUM_TRACKED; g++)
    begin : g_count
        glt_count_lane u_count (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cnt_ctrl),
            .changed    (changed[g]),
            .count_next (count_next[g])
        );
    end

    // The merge stage holds the references, position latch and colour and
    // cross state, and forms compensation and the end of move.
    glt_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (kind_t'(kind)),
        .movement (move_t'(movement)),
        .black    (black),
        .count    (count_next),
        .changed  (changed),
        .ctrl     (cnt_ctrl),
        .result   (result)
    );

    // Output register: the result waits here while the far side stalls.
    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign compensation    = result_reg.compensation;
    assign move_finished   = result_reg.move_finished;
    assign position_code   = result_reg.position_code;
    assign position_known  = result_reg.position_known;
    assign on_cross        = result_reg.on_cross;
    assign colour_order    = result_reg.colour_order;
    assign needs_alignment = result_reg.needs_alignment;

    // Every accepted item shows up in the output register in the next cycle.
    `GLT_ASSERT_NEXT(a_accept_fills_output, accept, out_valid, "accepted item produced no result")
    // A drained output with no new transfer behind it leaves the register empty.
    `GLT_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !accept, !out_valid, "result repeated")
    // Alignment is flagged only by start items and a move ends only on samples.
    `GLT_ASSERT(a_align_not_finish, !(out_valid && needs_alignment && move_finished), "start item ended a move")

endmodule
